// ----- hdl/mrs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared codes and types of the minimal-residual solver.
// ----------------------------------------------------------------------------
package mrs_pkg;

  localparam int FRAC_BITS = 16;

  // Item kinds on the input channel.
  localparam logic [1:0] KIND_MATRIX = 2'd0;
  localparam logic [1:0] KIND_RHS    = 2'd1;
  localparam logic [1:0] KIND_X      = 2'd2;
  localparam logic [1:0] KIND_START  = 2'd3;

  // Configuration register indexes (byte address 4 * index).
  localparam logic [1:0] REG_SIZE  = 2'd0;
  localparam logic [1:0] REG_TOL   = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

  // Controls of one vector cell.
  typedef struct packed {
    logic shift;
    logic wr_x;
    logic wr_b;
    logic wr_y;
    logic wr_p;
  } cell_ctl_t;

endpackage

// ----- hdl/mrs_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrs_in_if
// Input channel of the solver: load and start items.
// ----------------------------------------------------------------------------
interface mrs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [5:0]         row;
  logic [5:0]         col;
  logic signed [31:0] value;

  modport source (output valid, kind, row, col, value, input ready);
  modport sink (input valid, kind, row, col, value, output ready);
endinterface

// ----- hdl/mrs_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrs_out_if
// Output channel of the solver: solution elements with run status.
// ----------------------------------------------------------------------------
interface mrs_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         x_index;
  logic signed [31:0] x_value;
  logic               last;
  logic               converged;
  logic [15:0]        iterations;
  logic               divide_fault;

  modport source (output valid, x_index, x_value, last, converged, iterations, divide_fault,
                  input ready);
  modport sink (input valid, x_index, x_value, last, converged, iterations, divide_fault,
                output ready);
endinterface

// ----- hdl/mrs_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrs_cell
// One element of the vector ring: holds x, b, y and Ay of one index.
// ----------------------------------------------------------------------------
module mrs_cell
  import mrs_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  cell_ctl_t                    ctl_i,
  input  logic signed [VALUE_BITS-1:0] nx_i,
  input  logic signed [VALUE_BITS-1:0] nb_i,
  input  logic signed [VALUE_BITS-1:0] ny_i,
  input  logic signed [VALUE_BITS-1:0] np_i,
  input  logic signed [VALUE_BITS-1:0] wr_data_i,
  output logic signed [VALUE_BITS-1:0] x_o,
  output logic signed [VALUE_BITS-1:0] b_o,
  output logic signed [VALUE_BITS-1:0] y_o,
  output logic signed [VALUE_BITS-1:0] p_o
);

  logic signed [VALUE_BITS-1:0] x_q, b_q, y_q, p_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      x_q <= nx_i;
      b_q <= nb_i;
      y_q <= ny_i;
      p_q <= np_i;
    end else begin
      if (ctl_i.wr_x) x_q <= wr_data_i;
      if (ctl_i.wr_b) b_q <= wr_data_i;
      if (ctl_i.wr_y) y_q <= wr_data_i;
      if (ctl_i.wr_p) p_q <= wr_data_i;
    end
  end

  assign x_o = x_q;
  assign b_o = b_q;
  assign y_o = y_q;
  assign p_o = p_q;

endmodule

// ----- hdl/mrs_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrs_mac
// Pipelined multiply-accumulate: operand stage, product stage, accumulator.
// ----------------------------------------------------------------------------
module mrs_mac
  import mrs_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int ACC_W      = 72
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           clr_i,
  input  logic                           en_i,
  input  logic signed [VALUE_BITS-1:0]   a_i,
  input  logic signed [VALUE_BITS-1:0]   b_i,
  output logic signed [ACC_W-1:0]        acc_o,
  output logic signed [2*VALUE_BITS-1:0] prod_o
);

  logic signed [VALUE_BITS-1:0]   a_q, b_q;
  logic signed [2*VALUE_BITS-1:0] prod_q;
  logic signed [ACC_W-1:0]        acc_q;
  logic                           v1_q, v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= en_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_i;
    b_q    <= b_i;
    prod_q <= a_q * b_q;
    if (clr_i) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  assign acc_o  = acc_q;
  assign prod_o = prod_q;

endmodule

// ----- hdl/mrs_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mrs_div
  import mrs_pkg::*;
#(
  parameter int NUM_W = 88,
  parameter int DEN_W = 72
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   rem_sh, rem_sub;
  logic             fits;

  always_comb begin
    rem_sh  = {rem_q, quo_q[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    fits    = rem_sh >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so it fits DEN_W bits.
      rem_q <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- hdl/minimal_residual_solver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minimal_residual_solver
// Minimal-residual iteration solver for A x = b in signed fixed point.
// ----------------------------------------------------------------------------
// Usage: load A, b and the starting x through the input channel (kind 0, 1
// and 2), one item per cycle while idle. A start item (kind 3) runs the
// solver; the input channel then stays not ready until the whole solution
// has been sent. The result is n items on the output channel, index 0 first,
// with last set on element n-1 and the run status on every item.
// The vectors live in a ring of MAX_SIZE cells that rotates one full turn per
// row or vector product; the matrix sits in a memory with one write and
// one read port, read once per cycle. A run first forms |b|^2 and then the
// tolerance scale; each pass forms the residual y, y.y, Ay, y.Ay and Ay.Ay,
// divides and updates x. The final pass stops after the residual check.
// The output gives n items at up to one per cycle, then the ring realigns.
// A load item gives no result. The output register holds its item while
// the receiver stalls and the solver waits. Reset clears the control state
// and the configuration and control registers to their defaults; the stores
// and the multiplier and divider datapath registers are undefined until
// written.
// ----------------------------------------------------------------------------
module minimal_residual_solver
  import mrs_pkg::*;
#(
  parameter int MAX_SIZE   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  mrs_in_if.sink      in_i,
  mrs_out_if.source   out_o
);

  localparam int V     = VALUE_BITS;
  localparam int JW    = $clog2(MAX_SIZE);
  localparam int NW    = $clog2(MAX_SIZE + 1);
  localparam int AW    = $clog2(MAX_SIZE * MAX_SIZE);
  localparam int ACC_W = 2 * V + 8;
  localparam int NUM_W = ACC_W + FRAC_BITS;
  localparam int SATW  = NUM_W + 2;
  localparam int TW    = ACC_W + 32;

  typedef enum logic [3:0] {
    S_IDLE, S_REV, S_DRAIN, S_FINISH, S_TOL, S_DIV, S_UPD, S_OUT, S_ALIGN
  } state_e;

  typedef enum logic [2:0] {
    M_BB, M_RES, M_YY, M_PROD, M_YA, M_AA
  } mode_e;

  function automatic logic signed [V-1:0] sat_v(input logic signed [SATW-1:0] a);
    logic same;
    same = (a[SATW-1:V-1] == {(SATW-V+1){a[SATW-1]}});
    if (same) return a[V-1:0];
    return a[SATW-1] ? {1'b1, {(V-1){1'b0}}} : {1'b0, {(V-1){1'b1}}};
  endfunction

  function automatic logic [31:0] sat32(input logic signed [V-1:0] a);
    logic signed [SATW-1:0] w;
    logic same;
    w    = SATW'(a);
    same = (w[SATW-1:31] == {(SATW-31){w[SATW-1]}});
    if (same) return w[31:0];
    return w[SATW-1] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
  endfunction

  // Configuration
  logic [6:0]  size_q;
  logic [31:0] tol_q;
  logic [15:0] lim_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 7'd64;
      tol_q  <= 32'd43;
      lim_q  <= 16'd10000;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SIZE:  size_q <= pwdata[6:0];
        REG_TOL:   tol_q  <= pwdata;
        REG_LIMIT: lim_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SIZE:  prdata = {25'b0, size_q};
      REG_TOL:   prdata = tol_q;
      REG_LIMIT: prdata = {16'b0, lim_q};
      default:   prdata = '0;
    endcase
  end

  // Control registers
  state_e               state_q;
  mode_e                mode_q;
  logic [JW-1:0]        j_q, row_i_q;
  logic [NW-1:0]        n_q;
  logic [1:0]           drain_q, ph_q;
  logic [4:0]           tk_q;
  logic [15:0]          pass_q;
  logic                 conv_q, fault_q;
  logic [ACC_W-1:0]     bb_q;
  logic [TW-1:0]        tacc_q;
  logic signed [ACC_W-1:0] ya_q;
  logic signed [V-1:0]  t_q, bcap_q, opa_q, opb_q;
  logic                 use_mem_q, en_q;
  logic                 out_valid_q, out_last_q;
  logic [5:0]           out_idx_q;
  logic [31:0]          out_val_q;
  logic                 out_conv_q, out_fault_q;
  logic [15:0]          out_iter_q;

  // Ring of cells
  cell_ctl_t           ctl [MAX_SIZE];
  logic signed [V-1:0] cx [MAX_SIZE];
  logic signed [V-1:0] cb [MAX_SIZE];
  logic signed [V-1:0] cy [MAX_SIZE];
  logic signed [V-1:0] cp [MAX_SIZE];
  logic signed [V-1:0] wr_data, x_new, tail_x;

  // Datapath signals
  logic                   in_acc, row_ok, col_ok, mem_we;
  logic                   ld_x, ld_b, fin_y, fin_p, shift, out_free, out_load;
  logic signed [V-1:0]    v_sat, y_new, p_new, t_new, mac_a;
  logic signed [SATW-1:0] res_s, q_s;
  logic signed [ACC_W-1:0] acc;
  logic signed [2*V-1:0]  prod;
  logic                   yy_lt, j_last, j_in_n, row_last, div_done, div_start;
  logic [ACC_W-1:0]       ya_mag;
  logic [NUM_W-1:0]       div_quo;
  logic [AW-1:0]          mem_wa, mem_ra;
  logic signed [V-1:0]    mem_q [MAX_SIZE * MAX_SIZE];
  logic signed [V-1:0]    mem_rd_q;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && (state_q == S_IDLE);
  assign row_ok     = {1'b0, in_i.row} < 7'(MAX_SIZE);
  assign col_ok     = {1'b0, in_i.col} < 7'(MAX_SIZE);
  assign v_sat      = sat_v(SATW'(in_i.value));
  assign mem_we     = in_acc && (in_i.kind == KIND_MATRIX) && row_ok && col_ok;
  assign ld_x       = in_acc && (in_i.kind == KIND_X) && row_ok;
  assign ld_b       = in_acc && (in_i.kind == KIND_RHS) && row_ok;
  assign fin_y      = (state_q == S_FINISH) && (mode_q == M_RES);
  assign fin_p      = (state_q == S_FINISH) && (mode_q == M_PROD);
  assign j_last     = (j_q == JW'(MAX_SIZE - 1));
  assign j_in_n     = NW'(j_q) < n_q;
  assign row_last   = (NW'(row_i_q) + NW'(1)) == n_q;
  assign out_free   = !out_valid_q || out_o.ready;
  assign out_load   = (state_q == S_OUT) && out_free;

  assign mem_wa = AW'(in_i.row) * AW'(MAX_SIZE) + AW'(in_i.col);
  assign mem_ra = AW'(row_i_q) * AW'(MAX_SIZE) + AW'(j_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= v_sat;
    mem_rd_q <= mem_q[mem_ra];
  end

  // Arithmetic on the accumulator and the head of the ring
  always_comb begin
    res_s  = SATW'(acc) - (SATW'(bcap_q) <<< FRAC_BITS);
    y_new  = sat_v(res_s >>> FRAC_BITS);
    p_new  = sat_v(SATW'(acc) >>> FRAC_BITS);
    yy_lt  = $unsigned(acc) < tacc_q[TW-1:32];
    x_new  = j_in_n ? sat_v(SATW'(cx[0]) - (SATW'(prod) >>> FRAC_BITS)) : cx[0];
    ya_mag = ya_q[ACC_W-1] ? $unsigned(-ya_q) : $unsigned(ya_q);
    q_s    = $signed(SATW'(div_quo));
    t_new  = sat_v(ya_q[ACC_W-1] ? -q_s : q_s);
    mac_a  = use_mem_q ? mem_rd_q : opa_q;
  end

  assign shift = (state_q == S_REV) || (state_q == S_ALIGN) || out_load ||
                 ((state_q == S_UPD) && (ph_q == 2'd3));
  assign tail_x    = (state_q == S_UPD) ? x_new : cx[0];
  assign wr_data   = fin_y ? y_new : (fin_p ? p_new : v_sat);
  assign div_start = (state_q == S_FINISH) && (mode_q == M_AA) && (acc != '0);

  for (genvar k = 0; k < MAX_SIZE; k++) begin : g_cell
    localparam int NX = (k + 1) % MAX_SIZE;

    always_comb begin
      ctl[k].shift = shift;
      ctl[k].wr_x  = ld_x && (in_i.row == 6'(k));
      ctl[k].wr_b  = ld_b && (in_i.row == 6'(k));
      ctl[k].wr_y  = fin_y && (row_i_q == JW'(k));
      ctl[k].wr_p  = fin_p && (row_i_q == JW'(k));
    end

    mrs_cell #(
      .VALUE_BITS(V)
    ) u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl[k]),
      .nx_i     ((k == MAX_SIZE - 1) ? tail_x : cx[NX]),
      .nb_i     (cb[NX]),
      .ny_i     (cy[NX]),
      .np_i     (cp[NX]),
      .wr_data_i(wr_data),
      .x_o      (cx[k]),
      .b_o      (cb[k]),
      .y_o      (cy[k]),
      .p_o      (cp[k])
    );
  end

  mrs_mac #(
    .VALUE_BITS(V),
    .ACC_W     (ACC_W)
  ) u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .clr_i ((state_q == S_REV) && (j_q == '0)),
    .en_i  (en_q),
    .a_i   (mac_a),
    .b_i   (opb_q),
    .acc_o (acc),
    .prod_o(prod)
  );

  mrs_div #(
    .NUM_W(NUM_W),
    .DEN_W(ACC_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  ({ya_mag, {FRAC_BITS{1'b0}}}),
    .den_i  ($unsigned(acc)),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= M_BB;
      j_q         <= '0;
      row_i_q     <= '0;
      n_q         <= '0;
      drain_q     <= '0;
      ph_q        <= '0;
      tk_q        <= '0;
      pass_q      <= '0;
      conv_q      <= 1'b0;
      fault_q     <= 1'b0;
      bb_q        <= '0;
      tacc_q      <= '0;
      ya_q        <= '0;
      t_q         <= '0;
      bcap_q      <= '0;
      opa_q       <= '0;
      opb_q       <= '0;
      use_mem_q   <= 1'b0;
      en_q        <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_idx_q   <= '0;
      out_val_q   <= '0;
      out_conv_q  <= 1'b0;
      out_fault_q <= 1'b0;
      out_iter_q  <= '0;
    end else begin
      if (out_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && (in_i.kind == KIND_START)) begin
            if (size_q == 7'd0) n_q <= NW'(1);
            else if (size_q > 7'(MAX_SIZE)) n_q <= NW'(MAX_SIZE);
            else n_q <= NW'(size_q);
            pass_q  <= '0;
            conv_q  <= 1'b0;
            fault_q <= 1'b0;
            mode_q  <= M_BB;
            row_i_q <= '0;
            j_q     <= '0;
            state_q <= S_REV;
          end
        end
        S_REV: begin
          en_q      <= j_in_n;
          use_mem_q <= (mode_q == M_RES) || (mode_q == M_PROD);
          unique case (mode_q)
            M_BB: begin
              opa_q <= cb[0];
              opb_q <= cb[0];
            end
            M_RES:  opb_q <= cx[0];
            M_YY: begin
              opa_q <= cy[0];
              opb_q <= cy[0];
            end
            M_PROD: opb_q <= cy[0];
            M_YA: begin
              opa_q <= cy[0];
              opb_q <= cp[0];
            end
            M_AA: begin
              opa_q <= cp[0];
              opb_q <= cp[0];
            end
            default: ;
          endcase
          if ((mode_q == M_RES) && (j_q == row_i_q)) bcap_q <= cb[0];
          if (j_last) begin
            j_q     <= '0;
            drain_q <= '0;
            state_q <= S_DRAIN;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        S_DRAIN: begin
          en_q    <= 1'b0;
          drain_q <= drain_q + 1'b1;
          if (drain_q == 2'd2) state_q <= S_FINISH;
        end
        S_FINISH: begin
          state_q <= S_REV;
          j_q     <= '0;
          unique case (mode_q)
            M_BB: begin
              bb_q    <= $unsigned(acc);
              tacc_q  <= '0;
              tk_q    <= '0;
              state_q <= S_TOL;
            end
            M_RES: begin
              if (row_last) begin
                row_i_q <= '0;
                mode_q  <= M_YY;
              end else begin
                row_i_q <= row_i_q + 1'b1;
              end
            end
            M_YY: begin
              if (yy_lt) begin
                conv_q  <= 1'b1;
                state_q <= S_OUT;
              end else if (pass_q >= lim_q) begin
                state_q <= S_OUT;
              end else begin
                mode_q <= M_PROD;
              end
            end
            M_PROD: begin
              if (row_last) begin
                row_i_q <= '0;
                mode_q  <= M_YA;
              end else begin
                row_i_q <= row_i_q + 1'b1;
              end
            end
            M_YA: begin
              ya_q   <= acc;
              mode_q <= M_AA;
            end
            M_AA: begin
              if (acc == '0) begin
                fault_q <= 1'b1;
                state_q <= S_OUT;
              end else begin
                state_q <= S_DIV;
              end
            end
            default: ;
          endcase
        end
        S_TOL: begin
          // Shift-and-add product of |b|^2 and the tolerance, MSB first.
          tacc_q <= (tacc_q << 1) + (tol_q[5'd31 - tk_q] ? TW'(bb_q) : TW'(0));
          tk_q   <= tk_q + 1'b1;
          if (tk_q == 5'd31) begin
            mode_q  <= M_RES;
            row_i_q <= '0;
            j_q     <= '0;
            state_q <= S_REV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            t_q     <= t_new;
            j_q     <= '0;
            ph_q    <= '0;
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          // Four steps per element: operands, multiply, product, write back.
          ph_q <= ph_q + 1'b1;
          if (ph_q == 2'd0) begin
            opa_q     <= t_q;
            opb_q     <= cy[0];
            use_mem_q <= 1'b0;
            en_q      <= 1'b0;
          end
          if (ph_q == 2'd3) begin
            if (j_last) begin
              j_q     <= '0;
              pass_q  <= pass_q + 1'b1;
              mode_q  <= M_RES;
              row_i_q <= '0;
              state_q <= S_REV;
            end else begin
              j_q <= j_q + 1'b1;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= 6'(j_q);
            out_val_q   <= sat32(cx[0]);
            out_last_q  <= (NW'(j_q) + NW'(1)) == n_q;
            // The status travels with the item so that a new run cannot
            // change a held item.
            out_conv_q  <= conv_q;
            out_fault_q <= fault_q;
            out_iter_q  <= pass_q;
            if ((NW'(j_q) + NW'(1)) == n_q) begin
              if (j_last) begin
                j_q     <= '0;
                state_q <= S_IDLE;
              end else begin
                j_q     <= j_q + 1'b1;
                state_q <= S_ALIGN;
              end
            end else begin
              j_q <= j_q + 1'b1;
            end
          end
        end
        S_ALIGN: begin
          if (j_last) begin
            j_q     <= '0;
            state_q <= S_IDLE;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.x_index      = out_idx_q;
  assign out_o.x_value      = out_val_q;
  assign out_o.last         = out_last_q;
  assign out_o.converged    = out_conv_q;
  assign out_o.iterations   = out_iter_q;
  assign out_o.divide_fault = out_fault_q;

endmodule
